[rtl/bbpll_lf_pkg.sv]
`timescale 1ns / 1ps

package bbpll_lf_pkg;

  // Default sizing of the accumulator and the run counter
  localparam int unsigned MAX_FRACTION_BITS = 20;
  localparam int unsigned RUN_COUNT_BITS    = 8;

  // Field widths
  localparam int unsigned CODE_W      = 10;
  localparam int unsigned DCO_W       = 8;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned KP_W        = 10;
  localparam int unsigned FRAC_CFG_W  = 5;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned AFTER_W     = 8;
  localparam int unsigned DIR_W       = 2;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Code rails in 10-bit units
  localparam int unsigned CODE10_MAX         = 1023;
  localparam int unsigned UPPER_RAIL_CODE10  = 255 << 2;
  localparam int unsigned LOW_VISIBLE_CODE10 = 1 << 2;

  // Direction codes (two's complement)
  localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_START_CODE        = 3'd0,
    CFG_INTEGRAL_GAIN     = 3'd1,
    CFG_PROPORTIONAL_GAIN = 3'd2,
    CFG_FRACTION_BITS     = 3'd3,
    CFG_BOOST_AMOUNT      = 3'd4,
    CFG_BOOST_RUN         = 3'd5,
    CFG_RAIL_GUARD_ENABLE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [DCO_W-1:0]      start_code;
    logic [GAIN_W-1:0]     integral_gain;
    logic [KP_W-1:0]       proportional_gain;
    logic [FRAC_CFG_W-1:0] fraction_bits;
    logic [SHIFT_W-1:0]    boost_amount;
    logic [AFTER_W-1:0]    boost_run;
    logic                  rail_guard_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    start_code:        8'd0,
    integral_gain:     16'd128,
    proportional_gain: 10'd8,
    fraction_bits:     5'd2,
    boost_amount:      5'd0,
    boost_run:         8'd1,
    rail_guard_enable: 1'b0
  };

endpackage

[rtl/bbpll_lf_if.sv]
`timescale 1ns / 1ps

// Decision channel
interface bbpll_lf_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [bbpll_lf_pkg::DIR_W-1:0]    decision;

  modport source (output valid, command, decision, input ready);
  modport sink   (input valid, command, decision, output ready);
endinterface

// Code result channel
interface bbpll_lf_out_if;
  logic                              valid;
  logic                              ready;
  logic [bbpll_lf_pkg::DCO_W-1:0]    osc_code;
  logic [bbpll_lf_pkg::CODE_W-1:0]   fine_code;
  logic [bbpll_lf_pkg::DIR_W-1:0]    applied_direction;

  modport source (output valid, osc_code, fine_code, applied_direction, input ready);
  modport sink   (input valid, osc_code, fine_code, applied_direction, output ready);
endinterface

// Register write channel
interface bbpll_lf_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [bbpll_lf_pkg::CFG_INDEX_W-1:0]  reg_index;
  logic [bbpll_lf_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/bbpll_lf_step.sv]
`timescale 1ns / 1ps

// One loop filter update: rail handling, run tracking, integral step with
// optional boost, proportional kick and code extraction.
module bbpll_lf_step #(
  parameter int unsigned MAX_FRAC = bbpll_lf_pkg::MAX_FRACTION_BITS,
  parameter int unsigned RUN_W    = bbpll_lf_pkg::RUN_COUNT_BITS,
  localparam int unsigned ACC_W   = bbpll_lf_pkg::CODE_W + MAX_FRAC
) (
  input  bbpll_lf_pkg::cfg_t                 cfg_i,
  input  logic                               command_i,
  input  logic [bbpll_lf_pkg::DIR_W-1:0]     decision_i,
  input  logic [ACC_W-1:0]                   acc_i,
  input  logic [bbpll_lf_pkg::DIR_W-1:0]     prev_dir_i,
  input  logic [RUN_W-1:0]                   run_i,
  output logic [ACC_W-1:0]                   acc_o,
  output logic [bbpll_lf_pkg::DIR_W-1:0]     prev_dir_o,
  output logic [RUN_W-1:0]                   run_o,
  output logic [bbpll_lf_pkg::CODE_W-1:0]    fine_o,
  output logic [bbpll_lf_pkg::DCO_W-1:0]     dco_o,
  output logic [bbpll_lf_pkg::DIR_W-1:0]     dir_o
);

  localparam int unsigned CODE_W = bbpll_lf_pkg::CODE_W;
  localparam int unsigned SUM_W  = ACC_W + 1;
  localparam int unsigned FRAC_W = $clog2(MAX_FRAC + 2);
  localparam int unsigned FRAC_CMP_W = (FRAC_W > bbpll_lf_pkg::FRAC_CFG_W) ?
                                       FRAC_W : bbpll_lf_pkg::FRAC_CFG_W;
  localparam int unsigned KI_W   = bbpll_lf_pkg::GAIN_W + (2 ** bbpll_lf_pkg::SHIFT_W) - 1;
  localparam int unsigned CNT_W  = (RUN_W > bbpll_lf_pkg::AFTER_W) ?
                                   RUN_W : bbpll_lf_pkg::AFTER_W;

  // Saturating step, result clamped to [0, max]
  function automatic logic [ACC_W-1:0] sat_step(input logic [ACC_W-1:0] base,
                                                input logic [ACC_W-1:0] delta,
                                                input logic             up,
                                                input logic [ACC_W-1:0] max_val);
    logic [SUM_W-1:0] sum;
    logic [ACC_W-1:0] res;
    sum = {1'b0, base} + {1'b0, delta};
    if (up) begin
      res = (sum > {1'b0, max_val}) ? max_val : sum[ACC_W-1:0];
    end else if (delta > base) begin
      res = '0;
    end else begin
      res = base - delta;
      if (res > max_val) begin
        res = max_val;
      end
    end
    return res;
  endfunction

  logic [FRAC_W-1:0] frac;
  logic [ACC_W-1:0]  max_acc;
  logic [ACC_W-1:0]  kp_acc;
  logic [ACC_W-1:0]  acc_shr;
  logic [CODE_W-1:0] integ;
  logic              inc, dec;
  logic              low_guard, high_guard;
  logic              inc_eff, dec_eff;
  logic [bbpll_lf_pkg::DIR_W-1:0] dir;
  logic [RUN_W-1:0]  run_next;
  logic              boost;
  logic [KI_W-1:0]   ki_sel;
  logic [ACC_W-1:0]  ki_sat;
  logic [ACC_W-1:0]  acc_step;
  logic [ACC_W-1:0]  prop;
  logic [ACC_W-1:0]  prop_shr;

  // Effective fraction bits, clamped to the accumulator format
  assign frac = (FRAC_CMP_W'(cfg_i.fraction_bits) > FRAC_CMP_W'(MAX_FRAC)) ?
                FRAC_W'(MAX_FRAC) : FRAC_W'(cfg_i.fraction_bits);

  assign max_acc = ACC_W'(bbpll_lf_pkg::CODE10_MAX) << frac;
  assign kp_acc  = ACC_W'(cfg_i.proportional_gain) << frac;

  // Integral code, clamped to the 10-bit range
  assign acc_shr = acc_i >> frac;
  assign integ   = (acc_shr > ACC_W'(bbpll_lf_pkg::CODE10_MAX)) ?
                   CODE_W'(bbpll_lf_pkg::CODE10_MAX) : acc_shr[CODE_W-1:0];

  // Requests; pattern -2 counts as down
  assign inc = (decision_i == bbpll_lf_pkg::DIR_UP);
  assign dec = decision_i[1];

  // Proportional-path rail guards
  assign low_guard  = cfg_i.rail_guard_enable &&
                      ({1'b0, acc_i} < ({1'b0, kp_acc} +
                       (SUM_W'(bbpll_lf_pkg::LOW_VISIBLE_CODE10) << frac)));
  assign high_guard = cfg_i.rail_guard_enable &&
                      (({1'b0, acc_i} + {1'b0, kp_acc}) >=
                       (SUM_W'(bbpll_lf_pkg::UPPER_RAIL_CODE10) << frac));

  // Direction after rail handling
  assign inc_eff = (inc && !high_guard && (integ < CODE_W'(bbpll_lf_pkg::UPPER_RAIL_CODE10))) ||
                   (((integ == '0) || low_guard) && dec);
  assign dec_eff = (dec && !low_guard && (integ != '0)) ||
                   (((integ >= CODE_W'(bbpll_lf_pkg::UPPER_RAIL_CODE10)) || high_guard) && inc);
  assign dir = inc_eff ? bbpll_lf_pkg::DIR_UP :
               (dec_eff ? bbpll_lf_pkg::DIR_DOWN : bbpll_lf_pkg::DIR_NONE);

  // Same-direction run length, saturating
  assign run_next = (dir == prev_dir_i) ? ((run_i == '1) ? run_i : run_i + RUN_W'(1))
                                        : RUN_W'(1);

  // Integral gain with boost; oversized values cap above any legal step
  assign boost  = (cfg_i.boost_amount != '0) &&
                  (CNT_W'(run_next) >= CNT_W'(cfg_i.boost_run));
  assign ki_sel = boost ? (KI_W'(cfg_i.integral_gain) << cfg_i.boost_amount)
                        : KI_W'(cfg_i.integral_gain);
  assign ki_sat = (|ki_sel[KI_W-1:ACC_W]) ? '1 : ki_sel[ACC_W-1:0];

  // Integral update then proportional kick
  assign acc_step = sat_step(acc_i, ki_sat, inc_eff, max_acc);
  assign prop     = sat_step(acc_step, kp_acc, inc_eff, max_acc);
  assign prop_shr = prop >> frac;

  // Select restart, hold or step
  always_comb begin
    acc_o      = acc_i;
    prev_dir_o = bbpll_lf_pkg::DIR_NONE;
    run_o      = '0;
    fine_o     = integ;
    dco_o      = integ[CODE_W-1:2];
    dir_o      = bbpll_lf_pkg::DIR_NONE;
    if (command_i) begin
      acc_o  = ACC_W'({cfg_i.start_code, 2'b00}) << frac;
      fine_o = {cfg_i.start_code, 2'b00};
      dco_o  = cfg_i.start_code;
    end else if (dir != bbpll_lf_pkg::DIR_NONE) begin
      acc_o      = acc_step;
      prev_dir_o = dir;
      run_o      = run_next;
      fine_o     = prop_shr[CODE_W-1:0];
      dco_o      = prop_shr[CODE_W-1:2];
      dir_o      = dir;
    end
  end

endmodule

[rtl/bang_bang_pll_loop_filter.sv]
`timescale 1ns / 1ps

// Digital PI loop filter for a bang-bang PLL. Each input word is a phase
// decision (+1, 0, -1) or a restart from the start code register, and yields
// exactly one result word with the 8-bit DCO code, the 10-bit fine code and
// the direction actually applied. Throughput is one word per clock while the
// result register is not held: a word is captured in the input register, and
// its result is registered in the result register together with the
// accumulator and run-length state the following word needs. When the result
// register is held, the input register still takes one word and then the
// input stalls as well. The user must write registers through the
// configuration channel only while no word is in flight; the block itself
// does not enforce this. Writes to unused indexes are ignored.
module bang_bang_pll_loop_filter #(
  parameter int unsigned MAX_FRACTION_BITS = bbpll_lf_pkg::MAX_FRACTION_BITS,
  parameter int unsigned RUN_COUNT_BITS    = bbpll_lf_pkg::RUN_COUNT_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bbpll_lf_cfg_if.sink           cfg_i,
  bbpll_lf_in_if.sink            in_i,
  bbpll_lf_out_if.source         out_o
);

  localparam int unsigned ACC_W = bbpll_lf_pkg::CODE_W + MAX_FRACTION_BITS;

  bbpll_lf_pkg::cfg_t cfg_q, cfg_d;

  logic                               s1_valid_q;
  logic                               s1_command_q;
  logic [bbpll_lf_pkg::DIR_W-1:0]     s1_decision_q;

  logic [ACC_W-1:0]                   acc_q;
  logic [bbpll_lf_pkg::DIR_W-1:0]     prev_dir_q;
  logic [RUN_COUNT_BITS-1:0]          run_q;

  logic                               out_valid_q;
  logic [bbpll_lf_pkg::DCO_W-1:0]     dco_q;
  logic [bbpll_lf_pkg::CODE_W-1:0]    fine_q;
  logic [bbpll_lf_pkg::DIR_W-1:0]     dir_q;

  logic [ACC_W-1:0]                   acc_d;
  logic [bbpll_lf_pkg::DIR_W-1:0]     prev_dir_d;
  logic [RUN_COUNT_BITS-1:0]          run_d;
  logic [bbpll_lf_pkg::DCO_W-1:0]     dco_d;
  logic [bbpll_lf_pkg::CODE_W-1:0]    fine_d;
  logic [bbpll_lf_pkg::DIR_W-1:0]     dir_d;

  logic advance;
  logic in_fire;
  logic step_fire;

  // Register file writes
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (bbpll_lf_pkg::cfg_reg_e'(cfg_i.reg_index))
        bbpll_lf_pkg::CFG_START_CODE:
          cfg_d.start_code = cfg_i.wdata[bbpll_lf_pkg::DCO_W-1:0];
        bbpll_lf_pkg::CFG_INTEGRAL_GAIN:
          cfg_d.integral_gain = cfg_i.wdata[bbpll_lf_pkg::GAIN_W-1:0];
        bbpll_lf_pkg::CFG_PROPORTIONAL_GAIN:
          cfg_d.proportional_gain = cfg_i.wdata[bbpll_lf_pkg::KP_W-1:0];
        bbpll_lf_pkg::CFG_FRACTION_BITS:
          cfg_d.fraction_bits = cfg_i.wdata[bbpll_lf_pkg::FRAC_CFG_W-1:0];
        bbpll_lf_pkg::CFG_BOOST_AMOUNT:
          cfg_d.boost_amount = cfg_i.wdata[bbpll_lf_pkg::SHIFT_W-1:0];
        bbpll_lf_pkg::CFG_BOOST_RUN:
          cfg_d.boost_run = cfg_i.wdata[bbpll_lf_pkg::AFTER_W-1:0];
        bbpll_lf_pkg::CFG_RAIL_GUARD_ENABLE:
          cfg_d.rail_guard_enable = cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bbpll_lf_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline control: both stages move when the result register is free
  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire   = in_i.valid && in_i.ready;
  assign step_fire = s1_valid_q && advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_command_q  <= in_i.command;
      s1_decision_q <= in_i.decision;
    end
  end

  // Filter update
  bbpll_lf_step #(
    .MAX_FRAC (MAX_FRACTION_BITS),
    .RUN_W    (RUN_COUNT_BITS)
  ) u_step (
    .cfg_i      (cfg_q),
    .command_i  (s1_command_q),
    .decision_i (s1_decision_q),
    .acc_i      (acc_q),
    .prev_dir_i (prev_dir_q),
    .run_i      (run_q),
    .acc_o      (acc_d),
    .prev_dir_o (prev_dir_d),
    .run_o      (run_d),
    .fine_o     (fine_d),
    .dco_o      (dco_d),
    .dir_o      (dir_d)
  );

  // Loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      prev_dir_q <= bbpll_lf_pkg::DIR_NONE;
      run_q      <= '0;
    end else if (step_fire) begin
      acc_q      <= acc_d;
      prev_dir_q <= prev_dir_d;
      run_q      <= run_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      dco_q  <= dco_d;
      fine_q <= fine_d;
      dir_q  <= dir_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.osc_code          = dco_q;
  assign out_o.fine_code         = fine_q;
  assign out_o.applied_direction = dir_q;

endmodule
